/* sv/bdpc_pkg.sv */
// shared types and codes for the button debounce and press classifier
`timescale 1ns / 1ps

package bdpc_pkg;

   localparam int TimeWidth  = 32;
   localparam int DelayWidth = 16;
   localparam int CsrIdxWidth = 8;

   localparam logic [DelayWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [DelayWidth-1:0] LongPressReset = 16'd1000;

   // register indexes of the configuration port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE   = 8'd0,
      CSR_LONG_PRESS = 8'd1
   } csr_idx_type;

   // press status as seen on the result channel
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RISE = 2'd1,
      ST_HELD = 2'd2,
      ST_FALL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TIP_NONE  = 2'd0,
      TIP_SHORT = 2'd1,
      TIP_LONG  = 2'd2
   } tip_type;

   // state carried from one sample to the next
   typedef struct packed {
      logic                 prev_raw;
      logic [TimeWidth-1:0] last_change;
      logic [TimeWidth-1:0] press_start;
      status_type           status;
      tip_type              tip;
   } state_type;

   typedef struct packed {
      status_type status;
      tip_type    tip;
      logic       short_event;
      logic       long_event;
   } result_type;

endpackage

/* sv/bdpc_if.sv */
// channel interfaces: sample input, classified result, register writes
`timescale 1ns / 1ps

interface bdpc_req_if;
   logic        valid;
   logic        ready;
   logic        raw_level;
   logic [31:0] now_ms;

   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_status;
   logic [1:0] tip_kind;
   logic       short_event;
   logic       long_event;

   modport source (output valid, output press_status, output tip_kind,
                   output short_event, output long_event, input ready);
   modport sink (input valid, input press_status, input tip_kind,
                 input short_event, input long_event, output ready);
endinterface

interface bdpc_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/bdpc_update.sv */
// per-sample debounce, status step and press classification
`timescale 1ns / 1ps

module bdpc_update
   import bdpc_pkg::*;
(
   input  logic                  raw_level,
   input  logic [TimeWidth-1:0]  now_ms,
   input  logic [DelayWidth-1:0] debounce_ms,
   input  logic [DelayWidth-1:0] long_press_ms,
   input  state_type             state_cur,
   output state_type             state_nxt,
   output result_type            result
);

   logic                 changed;
   logic                 rise;
   logic [TimeWidth-1:0] since_change;
   logic [TimeWidth-1:0] since_press;
   logic                 settled;
   logic                 active;
   status_type           status_step;
   status_type           status_new;
   tip_type              tip_new;
   logic                 short_ev;

   // a raw change restarts the debounce time reference at this sample, a rise also the press time
   assign changed = raw_level != state_cur.prev_raw;
   assign rise    = changed && raw_level;

   assign since_change = changed ? '0 : now_ms - state_cur.last_change;
   assign since_press  = rise ? '0 : now_ms - state_cur.press_start;

   assign settled = since_change > {{(TimeWidth-DelayWidth){1'b0}}, debounce_ms};

   // status step once the level has settled
   always_comb begin
      unique case (state_cur.status)
         ST_RISE, ST_HELD: active = 1'b1;
         default:          active = 1'b0;
      endcase
      if (raw_level) begin
         status_step = active ? ST_HELD : ST_RISE;
      end else begin
         status_step = active ? ST_FALL : ST_IDLE;
      end
   end

   assign status_new = settled ? status_step : state_cur.status;

   // press length classification
   always_comb begin
      if (status_new == ST_IDLE) begin
         tip_new = TIP_NONE;
      end else if (since_press > {{(TimeWidth-DelayWidth){1'b0}}, long_press_ms}) begin
         tip_new = TIP_LONG;
      end else begin
         tip_new = TIP_SHORT;
      end
   end

   assign short_ev = (status_new == ST_FALL) && (tip_new == TIP_SHORT);

   assign state_nxt.prev_raw    = raw_level;
   assign state_nxt.last_change = changed ? now_ms : state_cur.last_change;
   assign state_nxt.press_start = rise ? now_ms : state_cur.press_start;
   assign state_nxt.status      = status_new;
   assign state_nxt.tip         = tip_new;

   assign result.status      = status_new;
   assign result.tip         = tip_new;
   assign result.short_event = short_ev;
   assign result.long_event  = !short_ev && (tip_new == TIP_LONG)
                               && (state_cur.tip != TIP_LONG);

endmodule

/* sv/button_debounce_press_classifier_core.sv */
// top level: input register, classification stage and result register
`timescale 1ns / 1ps

// Button debouncer with short and long press classification. Each transfer on
// req_chan carries one sampled pin level and a wrapping millisecond timestamp;
// each produces exactly one result on rsp_chan, in order. The block takes one
// sample per cycle unless the result side stalls; samples land in an input
// register, and the single classification stage updates the debounce state
// and the result register in the same cycle, so the sample-to-sample state
// loop closes through the state register. A stalled result holds the pipeline
// but the input register still absorbs one further sample. Registers (debounce_ms
// at index 0, long_press_ms at index 1, low 16 bits kept, other indexes ignored)
// are written through csr_chan, which is always ready; write them only while idle.

module button_debounce_press_classifier_core
   import bdpc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   bdpc_req_if.sink   req_chan,
   bdpc_rsp_if.source rsp_chan,
   bdpc_csr_if.sink   csr_chan
);

   logic [DelayWidth-1:0] debounce_ff;
   logic [DelayWidth-1:0] long_press_ff;

   logic                 in_valid_ff;
   logic                 in_level_ff;
   logic [TimeWidth-1:0] in_now_ff;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       out_valid_ff;

   logic advance;
   logic req_take;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DebounceReset;
         long_press_ff <= LongPressReset;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_chan.data;
            CSR_LONG_PRESS: long_press_ff <= csr_chan.data;
            default:        ;
         endcase
      end
   end

   // pipeline flow control
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_chan.raw_level;
         in_now_ff   <= req_chan.now_ms;
      end
   end

   // classification stage
   bdpc_update u_update (
      .raw_level     (in_level_ff),
      .now_ms        (in_now_ff),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .result        (result_in)
   );

   // debounce state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.prev_raw    <= 1'b0;
         state_ff.last_change <= '0;
         state_ff.press_start <= '0;
         state_ff.status      <= ST_IDLE;
         state_ff.tip         <= TIP_NONE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.press_status = result_ff.status;
   assign rsp_chan.tip_kind     = result_ff.tip;
   assign rsp_chan.short_event  = result_ff.short_event;
   assign rsp_chan.long_event   = result_ff.long_event;

endmodule

/* sv/bdpc_checker.sv */
// port-level checks on the classifier results, bound to the top level
`timescale 1ns / 1ps

module bdpc_checker
   import bdpc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] press_status,
   input logic [1:0] tip_kind,
   input logic       short_event,
   input logic       long_event
);

   // the two events never fire together
   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(short_event && long_event))
      else $error("short and long event together");

   // a short event only on a falling edge of a short press
   a_short_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && short_event) |-> (press_status == ST_FALL && tip_kind == TIP_SHORT))
      else $error("short event without short falling edge");

   // a long event only with a long tip
   a_long_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && long_event) |-> (tip_kind == TIP_LONG))
      else $error("long event without long tip");

   // tip is none exactly when the button is not pressed
   a_tip_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((tip_kind == TIP_NONE) == (press_status == ST_IDLE)))
      else $error("tip kind disagrees with press status");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(press_status)
                                     && $stable(tip_kind) && $stable(short_event)
                                     && $stable(long_event)))
      else $error("stalled result changed");

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .press_status (rsp_chan.press_status),
   .tip_kind     (rsp_chan.tip_kind),
   .short_event  (rsp_chan.short_event),
   .long_event   (rsp_chan.long_event)
);

/* tb/tb_top.sv */
// self-checking bench for the button debounce and press classifier core
`timescale 1ns / 1ps

module tb_top;
   import bdpc_pkg::*;

   localparam int StallLimit = 2000;
   localparam int HoldOffCycles = 300;
   localparam int SettleCycles = 4;
   localparam logic [CsrIdxWidth-1:0] CsrIdxLast = 8'hFF;

   // tracks the debounce and press state and queues the classification due per sample
   class press_tracker;
      logic [DelayWidth-1:0] debounce;
      logic [DelayWidth-1:0] long_press;
      logic                  last_level;
      logic [TimeWidth-1:0]  change_at;
      logic [TimeWidth-1:0]  press_at;
      status_type            status;
      tip_type               tip;
      result_type            outcomes_due[$];
      int                    errors;

      function new();
         debounce   = DebounceReset;
         long_press = LongPressReset;
         last_level = 1'b0;
         change_at  = '0;
         press_at   = '0;
         status     = ST_IDLE;
         tip        = TIP_NONE;
         errors     = 0;
      endfunction

      function void set_reg(logic [CsrIdxWidth-1:0] idx, logic [DelayWidth-1:0] value);
         case (idx)
            CSR_DEBOUNCE: debounce = value;
            CSR_LONG_PRESS: long_press = value;
            default: ;
         endcase
      endfunction

      function status_type follow_level(status_type cur, logic level);
         bit active;
         active = (cur == ST_RISE) || (cur == ST_HELD);
         if (level) return active ? ST_HELD : ST_RISE;
         return active ? ST_FALL : ST_IDLE;
      endfunction

      function void note_sample(logic level, logic [TimeWidth-1:0] now);
         tip_type              old_tip;
         logic [TimeWidth-1:0] held_for;
         logic [TimeWidth-1:0] pressed_for;
         result_type           outcome;
         old_tip = tip;
         // any raw change restarts the debounce time, a rise marks the press start
         if (level != last_level) begin
            change_at = now;
            if (level) press_at = now;
         end
         held_for = now - change_at;
         if (held_for > TimeWidth'(debounce)) status = follow_level(status, level);
         last_level = level;
         // tip kind from the time since the press started
         pressed_for = now - press_at;
         if (status == ST_IDLE) tip = TIP_NONE;
         else if (pressed_for > TimeWidth'(long_press)) tip = TIP_LONG;
         else tip = TIP_SHORT;
         outcome.status      = status;
         outcome.tip         = tip;
         outcome.short_event = (status == ST_FALL) && (tip == TIP_SHORT);
         outcome.long_event  = !outcome.short_event && (tip == TIP_LONG)
                               && (old_tip != TIP_LONG);
         outcomes_due.push_back(outcome);
      endfunction

      function void check_result(logic [1:0] got_status, logic [1:0] got_tip,
                                 logic got_short, logic got_long);
         result_type want;
         if (outcomes_due.size() == 0) begin
            $error("result transfer with no sample outstanding");
            errors++;
            return;
         end
         want = outcomes_due.pop_front();
         if (got_status !== want.status) begin
            $error("press_status: expected %0d, got %0d", want.status, got_status);
            errors++;
         end
         if (got_tip !== want.tip) begin
            $error("tip_kind: expected %0d, got %0d", want.tip, got_tip);
            errors++;
         end
         if (got_short !== want.short_event) begin
            $error("short_event: expected %0d, got %0d", want.short_event, got_short);
            errors++;
         end
         if (got_long !== want.long_event) begin
            $error("long_event: expected %0d, got %0d", want.long_event, got_long);
            errors++;
         end
      endfunction

      function int outstanding();
         return outcomes_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   bdpc_req_if req_chan ();
   bdpc_rsp_if rsp_chan ();
   bdpc_csr_if csr_chan ();

   button_debounce_press_classifier_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   press_tracker tracker = new();
   int quiet_cycles = 0;
   bit hold_off_req = 1'b0;
   bit steady = 1'b0;
   int cur_debounce = int'(DebounceReset);
   int cur_long_press = int'(LongPressReset);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transfer monitor: register writes, samples and results, plus the quiet counter
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            tracker.set_reg(csr_chan.index, csr_chan.data);
            moved = 1'b1;
         end
         if (req_chan.valid && req_chan.ready) begin
            tracker.note_sample(req_chan.raw_level, req_chan.now_ms);
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            tracker.check_result(rsp_chan.press_status, rsp_chan.tip_kind,
                                 rsp_chan.short_event, rsp_chan.long_event);
            moved = 1'b1;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("button_debounce_press_classifier_core: mismatch");
      $finish;
   end

   // result side back-pressure, with one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int pick;
         pick = $urandom_range(0, 99);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end else if (steady || pick >= 35) begin
            rsp_chan.ready <= 1'b1;
            repeat (steady ? 1 : $urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat (pick < 8 ? $urandom_range(10, 40) : $urandom_range(1, 3))
               @(negedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one sample transfer; entered and left at a falling edge
   task automatic send_sample(input logic level, input logic [TimeWidth-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.raw_level <= level;
      req_chan.now_ms    <= now;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // one register write, with the write channel then left idle
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [DelayWidth-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_delays(input int debounce, input int long_press);
      cur_debounce   = debounce;
      cur_long_press = long_press;
      write_reg(CSR_DEBOUNCE, DelayWidth'(debounce));
      write_reg(CSR_LONG_PRESS, DelayWidth'(long_press));
   endtask

   // stop offering and let every due result come out
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // press sequences with bounce around a running clock, some pure noise
   task automatic run_random(input int count);
      logic [TimeWidth-1:0] ms;
      logic                 target;
      logic                 level;
      int                   pick;
      ms = $urandom;
      target = 1'b0;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            ms = $urandom;
            send_sample(1'($urandom_range(0, 1)), ms);
         end else begin
            if ($urandom_range(0, 99) < 12) target = ~target;
            pick = $urandom_range(0, 99);
            if (pick < 45) ms += $urandom_range(0, cur_debounce + 1);
            else if (pick < 75) ms += $urandom_range(0, 2);
            else if (pick < 97) ms += $urandom_range(0, cur_long_press / 8 + 2);
            else ms += $urandom_range(0, 200000);
            level = ($urandom_range(0, 99) < 15) ? ~target : target;
            send_sample(level, ms);
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.raw_level = 1'b0;
      req_chan.now_ms    = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_DEBOUNCE;
      csr_chan.data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset delays: exact boundaries, long event, bounce, short event
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd10);
      send_sample(1'b1, 32'd60);
      send_sample(1'b1, 32'd61);
      send_sample(1'b1, 32'd62);
      send_sample(1'b1, 32'd1010);
      send_sample(1'b1, 32'd1011);
      send_sample(1'b0, 32'd1012);
      send_sample(1'b0, 32'd1063);
      send_sample(1'b0, 32'd1064);
      send_sample(1'b1, 32'd2000);
      send_sample(1'b0, 32'd2010);
      send_sample(1'b1, 32'd2020);
      send_sample(1'b1, 32'd2071);
      send_sample(1'b0, 32'd2100);
      send_sample(1'b0, 32'd2151);
      send_sample(1'b0, 32'd2152);
      // press across the timestamp wrap
      send_sample(1'b1, 32'hFFFF_FFF0);
      send_sample(1'b1, 32'h0000_0023);
      send_sample(1'b1, 32'h0000_03F0);
      send_sample(1'b0, 32'h0000_0400);
      send_sample(1'b0, 32'h0000_0433);
      send_sample(1'b0, 32'hFFFF_FFFF);
      drain();

      // writes to unused indexes must leave both delays alone
      write_reg(CsrIdxWidth'($urandom_range(CSR_LONG_PRESS + 1, CsrIdxLast)),
                DelayWidth'($urandom));
      write_reg(CsrIdxLast, DelayWidth'($urandom));
      hold_off_req = 1'b1;
      run_random(300);
      drain();

      // zero delays, no idling on either side
      program_delays(0, 0);
      steady = 1'b1;
      run_random(250);
      steady = 1'b0;
      drain();

      program_delays(65535, 65535);
      run_random(300);
      drain();

      repeat (4) begin
         program_delays($urandom_range(0, 40), $urandom_range(0, 400));
         run_random(215);
         drain();
      end

      program_delays($urandom_range(0, 65535), $urandom_range(0, 65535));
      run_random(250);
      drain();

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0)
         $display("button_debounce_press_classifier_core: match");
      else
         $display("button_debounce_press_classifier_core: mismatch");
      $finish;
   end

endmodule

/* files.f */
sv/bdpc_pkg.sv
sv/bdpc_if.sv
sv/bdpc_update.sv
sv/button_debounce_press_classifier_core.sv
sv/bdpc_checker.sv
tb/tb_top.sv
